[design/gvs_pkg.sv]
// Shared constants, register codes and control types of the vertical Sobel filter.
`timescale 1ns / 1ps

package gvs_pkg;

  // Default build parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int GRAY_FRAC_DEF  = 16;

  // Fixed field widths
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int ROW_W     = CFG_W + 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Configuration reset values
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd256;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd256;

  // Input item kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Output clamp ceiling
  localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

  // Per-item border masks and result control
  typedef struct packed {
    logic emit;
    logic last;
    logic left_en;
    logic right_en;
    logic top_en;
    logic bot_en;
  } tap_flags_t;

endpackage

[design/gvs_if.sv]
// Channel interfaces: pixel input, edge result output and configuration write.
`timescale 1ns / 1ps

interface gvs_pix_if import gvs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;

  modport source (output valid, req_type, red, green, blue, input ready);
  modport sink   (input valid, req_type, red, green, blue, output ready);
endinterface

interface gvs_edge_if import gvs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] edge_value;
  logic             frame_last;

  modport source (output valid, edge_value, frame_last, input ready);
  modport sink   (input valid, edge_value, frame_last, output ready);
endinterface

interface gvs_cfg_if import gvs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/gvs_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module gvs_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/gvs_seq.sv]
// Frame geometry registers, raster position counters and border mask generation.
`timescale 1ns / 1ps

module gvs_seq import gvs_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 accept,
  output logic [ADDR_W-1:0]    col_addr,
  output tap_flags_t           flags
);

  localparam int CNT_W = (ADDR_W + 1 > ROW_W) ? ADDR_W + 1 : ROW_W;

  logic [CFG_W-1:0]  width_r, width_nxt;
  logic [CFG_W-1:0]  height_r, height_nxt;
  logic [ADDR_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  logic [CFG_W-1:0]  eff_w;
  logic [CFG_W-1:0]  eff_h;
  logic [CNT_W-1:0]  wx, hx, colx, rowx;
  logic [CNT_W-1:0]  ctr_col, ctr_row, col_inc;
  logic              col_zero;
  logic              cfg_hit;

  // Clamp the width to what the line store holds; a zero width or height counts as one
  always_comb begin
    if (width_r == '0) begin
      eff_w = CFG_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      eff_w = CFG_W'(MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    eff_h = (height_r == '0) ? CFG_W'(1) : height_r;
  end

  assign wx   = CNT_W'(eff_w);
  assign hx   = CNT_W'(eff_h);
  assign colx = CNT_W'(col_r);
  assign rowx = CNT_W'(row_r);
  assign col_zero = (col_r == '0);

  // Locate the pixel whose window closes with this item
  always_comb begin
    ctr_col = col_zero ? wx - CNT_W'(1) : colx - CNT_W'(1);
    ctr_row = col_zero ? rowx - CNT_W'(2) : rowx - CNT_W'(1);
    flags.emit     = (rowx >= CNT_W'(2)) || ((rowx == CNT_W'(1)) && !col_zero);
    flags.last     = (rowx == hx + CNT_W'(1)) && col_zero;
    flags.left_en  = (ctr_col != '0);
    flags.right_en = (ctr_col != wx - CNT_W'(1));
    flags.top_en   = (ctr_row != '0);
    flags.bot_en   = (ctr_row != hx - CNT_W'(1));
  end

  assign col_addr = col_r;
  assign col_inc  = colx + CNT_W'(1);
  assign cfg_hit  = cfg_we && ((cfg_index == REG_IMAGE_WIDTH) ||
                               (cfg_index == REG_IMAGE_HEIGHT));

  // Register writes restart the frame; transfers advance the raster position
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (cfg_we && (cfg_index == REG_IMAGE_WIDTH)) begin
      width_nxt = cfg_data;
    end
    if (cfg_we && (cfg_index == REG_IMAGE_HEIGHT)) begin
      height_nxt = cfg_data;
    end
    priority if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept && flags.last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept && (col_inc >= wx)) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
    end else if (accept) begin
      col_nxt = col_inc[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMAGE_WIDTH_RST;
      height_r <= IMAGE_HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

[design/gvs_window.sv]
// Sliding column window, vertical Sobel sum, clamp and output register.
`timescale 1ns / 1ps

module gvs_window import gvs_pkg::*; #(
  parameter int LUM_W  = PIX_W + GRAY_FRAC_DEF,
  parameter int FRAC_W = GRAY_FRAC_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s1_valid,
  input  tap_flags_t       s1_flags,
  input  logic [LUM_W-1:0] new_top,
  input  logic [LUM_W-1:0] new_bot,
  input  logic             out_ready,
  output logic             advance,
  output logic             out_valid,
  output logic [PIX_W-1:0] edge_value,
  output logic             frame_last
);

  localparam int SUM_W = LUM_W + 2;
  localparam int ACC_W = SUM_W + 1;
  localparam int Q_W   = SUM_W - FRAC_W;

  logic [LUM_W-1:0] top_r [3];
  logic [LUM_W-1:0] bot_r [3];
  logic             s2_valid_r;
  tap_flags_t       s2_flags_r;
  logic             out_valid_r;
  logic [PIX_W-1:0] edge_r, edge_nxt;
  logic             last_r;

  logic [LUM_W-1:0] t0, t1, t2, b0, b1, b2;
  logic [SUM_W-1:0] top_sum, bot_sum;
  logic [ACC_W-1:0] acc;
  logic [Q_W-1:0]   quot;

  // Hold everything only when a result is due and the output is still full
  assign advance = !(out_valid_r && !out_ready && s2_valid_r && s2_flags_r.emit);

  // Shift the window by one column per transfer
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      top_r[0] <= top_r[1];
      top_r[1] <= top_r[2];
      top_r[2] <= new_top;
      bot_r[0] <= bot_r[1];
      bot_r[1] <= bot_r[2];
      bot_r[2] <= new_bot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_flags_r <= s1_flags;
    end
  end

  // Mask taps that fall outside the image
  always_comb begin
    t0 = (s2_flags_r.left_en && s2_flags_r.top_en) ? top_r[0] : '0;
    t1 = s2_flags_r.top_en ? top_r[1] : '0;
    t2 = (s2_flags_r.right_en && s2_flags_r.top_en) ? top_r[2] : '0;
    b0 = (s2_flags_r.left_en && s2_flags_r.bot_en) ? bot_r[0] : '0;
    b1 = s2_flags_r.bot_en ? bot_r[1] : '0;
    b2 = (s2_flags_r.right_en && s2_flags_r.bot_en) ? bot_r[2] : '0;
  end

  // Weight 1,2,1 above minus 1,2,1 below, then clamp and drop the fraction
  always_comb begin
    top_sum = SUM_W'(t0) + {1'b0, t1, 1'b0} + SUM_W'(t2);
    bot_sum = SUM_W'(b0) + {1'b0, b1, 1'b0} + SUM_W'(b2);
    acc     = {1'b0, top_sum} - {1'b0, bot_sum};
    quot    = acc[SUM_W-1:FRAC_W];
    if (acc[ACC_W-1]) begin
      edge_nxt = '0;
    end else if (quot > Q_W'(EDGE_MAX)) begin
      edge_nxt = EDGE_MAX;
    end else begin
      edge_nxt = quot[PIX_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s2_valid_r && s2_flags_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid_r && s2_flags_r.emit) begin
      edge_r <= edge_nxt;
      last_r <= s2_flags_r.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign edge_value = edge_r;
  assign frame_last = last_r;

endmodule

[design/gray_vertical_sobel_filter_unit.sv]
// Top level of the grey-scale vertical Sobel edge filter.
`timescale 1ns / 1ps

// Vertical Sobel edge filter on a raster RGB pixel stream.
// in_pix carries one item per transfer: a pixel (red, green, blue) or a flush
// item that stands for a padding position. out_edge returns the clamped 8-bit
// vertical gradient, with frame_last set on the final pixel of the frame.
// cfg_wr writes image_width (index 0) and image_height (index 1); a write
// restarts the frame and is meant to be issued while the block is idle.
// The result for pixel q leaves with input item q+W+1, so after the last pixel
// of a frame the host sends W+1 flush items. The completing item passes the
// stage one registers, the window registers and the output register to out_edge.
// Throughput is one item per clock when no result stalls on out_edge: every item
// reads and writes back one line store entry (upper and middle rows packed), a
// registered read, forwarded when the same column is hit on consecutive items.
// Borders are masked by position, so the line store needs no clearing pass
// and is usable straight after reset. Reset clears the pipeline and the
// counters and sets the geometry to 256 x 256. When out_edge stalls with a
// result pending the pipeline holds; items that produce no result still flow.

module gray_vertical_sobel_filter_unit import gvs_pkg::*; #(
  parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
  parameter int GRAY_FRAC_BITS = GRAY_FRAC_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  gvs_pix_if.sink    in_pix,
  gvs_edge_if.source out_edge,
  gvs_cfg_if.sink    cfg_wr
);

  localparam int ADDR_W  = $clog2(MAX_WIDTH);
  localparam int LUM_W   = PIX_W + GRAY_FRAC_BITS;
  localparam int LINE_W  = 2 * LUM_W;

  // Luminance weights, rounded at elaboration
  localparam longint unsigned GRAY_ONE = 64'd1 << GRAY_FRAC_BITS;
  localparam longint unsigned WR_FULL  = (64'd2126 * GRAY_ONE + 64'd5000) / 64'd10000;
  localparam longint unsigned WG_FULL  = (64'd7152 * GRAY_ONE + 64'd5000) / 64'd10000;
  localparam longint unsigned WB_FULL  = (64'd722 * GRAY_ONE + 64'd5000) / 64'd10000;
  localparam logic [LUM_W-1:0] WEIGHT_R = WR_FULL[LUM_W-1:0];
  localparam logic [LUM_W-1:0] WEIGHT_G = WG_FULL[LUM_W-1:0];
  localparam logic [LUM_W-1:0] WEIGHT_B = WB_FULL[LUM_W-1:0];

  logic              advance;
  logic              accept;
  logic [ADDR_W-1:0] seq_addr;
  tap_flags_t        seq_flags;
  logic [LUM_W-1:0]  lum_in;

  logic              s1_valid_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [LUM_W-1:0]  s1_lum_r;
  tap_flags_t        s1_flags_r;
  logic              fwd_r, fwd_nxt;
  logic [LINE_W-1:0] fwd_data_r;

  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] line_rd;
  logic [LINE_W-1:0] line_wr;
  logic              ram_we;

  assign in_pix.ready = advance;
  assign cfg_wr.ready = 1'b1;
  assign accept       = in_pix.valid && advance;

  // Raster position and border masks
  gvs_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_wr.valid),
    .cfg_index (cfg_wr.index),
    .cfg_data  (cfg_wr.data),
    .accept    (accept),
    .col_addr  (seq_addr),
    .flags     (seq_flags)
  );

  // Luminance of the incoming item; flush items are zero
  always_comb begin
    if (in_pix.req_type == REQ_FLUSH) begin
      lum_in = '0;
    end else begin
      lum_in = WEIGHT_R * LUM_W'(in_pix.red) + WEIGHT_G * LUM_W'(in_pix.green)
             + WEIGHT_B * LUM_W'(in_pix.blue);
    end
  end

  // Line store: upper row in the high half, middle row in the low half
  gvs_ram #(
    .DATA_W (LINE_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (line_wr),
    .re    (accept),
    .raddr (seq_addr),
    .rdata (ram_rdata)
  );

  // Forward the entry being written when the next item reads the same column
  assign line_rd = fwd_r ? fwd_data_r : ram_rdata;
  assign line_wr = {line_rd[LUM_W-1:0], s1_lum_r};
  assign ram_we  = s1_valid_r && advance;

  always_comb begin
    fwd_nxt = fwd_r;
    if (accept) begin
      fwd_nxt = s1_valid_r && (s1_addr_r == seq_addr);
    end else if (advance) begin
      fwd_nxt = 1'b0;
    end
  end

  // Stage one: line store read returns, write back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      fwd_r <= fwd_nxt;
      if (advance) begin
        s1_valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r  <= seq_addr;
      s1_lum_r   <= lum_in;
      s1_flags_r <= seq_flags;
      fwd_data_r <= line_wr;
    end
  end

  // Window, kernel and output register
  gvs_window #(
    .LUM_W  (LUM_W),
    .FRAC_W (GRAY_FRAC_BITS)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid_r),
    .s1_flags   (s1_flags_r),
    .new_top    (line_rd[LINE_W-1:LUM_W]),
    .new_bot    (s1_lum_r),
    .out_ready  (out_edge.ready),
    .advance    (advance),
    .out_valid  (out_edge.valid),
    .edge_value (out_edge.edge_value),
    .frame_last (out_edge.frame_last)
  );

  // A stalled cycle neither takes an item nor writes the line store
  assert property (@(posedge clk) disable iff (!rst_n)
    !advance |-> !accept && !ram_we)
    else $error("transfer or line store write during stall");

  // A stalled item in stage one keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    !advance && s1_valid_r |=> s1_valid_r && $stable(s1_lum_r) && $stable(s1_addr_r))
    else $error("stage one item lost during stall");

  // Forwarding only ever applies to an item held in stage one
  assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("forwarding flag without stage one item");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the grey-scale vertical Sobel filter, with its own line-store model.
`timescale 1ns / 1ps

module testbench;
  import gvs_pkg::*;

  localparam int LUM_W = PIX_W + GRAY_FRAC_DEF;
  localparam longint unsigned GRAY_ONE = 64'd1 << GRAY_FRAC_DEF;
  localparam longint unsigned LUM_R = (64'd2126 * GRAY_ONE + 64'd5000) / 64'd10000;
  localparam longint unsigned LUM_G = (64'd7152 * GRAY_ONE + 64'd5000) / 64'd10000;
  localparam longint unsigned LUM_B = (64'd722 * GRAY_ONE + 64'd5000) / 64'd10000;

  localparam int RANDOM_ITEMS  = 880;
  localparam int TALL_CUT      = 40;
  localparam int SETTLE_CYCLES = 12;
  localparam int RUN_LIMIT_NS  = 5_000_000;

  // Spare register indexes: writes there must leave geometry and frame alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             frame_last;
  } edge_res_t;

  logic clk;
  logic rst_n;

  gvs_pix_if  pix_ch ();
  gvs_edge_if res_ch ();
  gvs_cfg_if  cfg_ch ();

  gray_vertical_sobel_filter_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (pix_ch),
    .out_edge (res_ch),
    .cfg_wr   (cfg_ch)
  );

  // Model state: two rows of luminance per column and the 3x3 window
  logic [LUM_W-1:0] upper_lum [MAX_WIDTH_DEF];
  logic [LUM_W-1:0] middle_lum [MAX_WIDTH_DEF];
  logic [LUM_W-1:0] win_lum [3][3];  // [column][top, middle, bottom]
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      emitted;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  pix_item_t pixel_backlog [$];
  edge_res_t pending_edges [$];
  pix_item_t driven_item;
  edge_res_t want_edge;

  int fail_count      = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int frames_seen     = 0;
  int reg_writes      = 0;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;

  function automatic int unsigned eff_w();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    return (height_reg == '0) ? 1 : height_reg;
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    emitted = 0;
  endfunction

  function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] val);
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = val;
      restart_frame();
    end else if (idx == REG_IMAGE_HEIGHT) begin
      height_reg = val;
      restart_frame();
    end
  endfunction

  // Advance the model by one item and queue the edge value it completes, if any
  function automatic void advance_sobel(input pix_item_t it);
    int unsigned     w, h, pc, pr, r, c;
    longint unsigned lum, pos, total, val;
    longint          acc, wt;
    bit              last;
    edge_res_t       res;
    w    = eff_w();
    h    = eff_h();
    pc   = col_pos;
    pr   = row_pos;
    lum  = 0;
    last = 1'b0;
    if (it.req_type == REQ_PIXEL)
      lum = LUM_R * it.red + LUM_G * it.green + LUM_B * it.blue;
    if (pc >= MAX_WIDTH_DEF) pc = 0;

    // shift the window left and load the new right column
    for (int j = 0; j < 3; j++) begin
      win_lum[0][j] = win_lum[1][j];
      win_lum[1][j] = win_lum[2][j];
    end
    win_lum[2][0]  = upper_lum[pc];
    win_lum[2][1]  = middle_lum[pc];
    win_lum[2][2]  = lum[LUM_W-1:0];
    upper_lum[pc]  = middle_lum[pc];
    middle_lum[pc] = lum[LUM_W-1:0];

    pos   = 64'(pr) * 64'(w) + 64'(pc);
    total = 64'(w) * 64'(h);
    if (pos >= 64'(w) + 64'd1 && 64'(emitted) < total) begin
      // centre pixel sits one column back, wrapping to the previous row
      if (pc >= 1) begin
        r = pr - 1;
        c = pc - 1;
      end else begin
        r = pr - 2;
        c = w - 1;
      end
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        wt = (k == 1) ? 2 : 1;
        // drop columns and rows that fall outside the image
        if ((k == 0 && c == 0) || (k == 2 && c == w - 1)) continue;
        if (r != 0) acc += wt * longint'(win_lum[k][0]);
        if (r != h - 1) acc -= wt * longint'(win_lum[k][2]);
      end
      if (acc < 0) begin
        val = 0;
      end else begin
        val = 64'(acc) >> GRAY_FRAC_DEF;
        if (val > EDGE_MAX) val = EDGE_MAX;
      end
      emitted++;
      last           = (64'(emitted) == total);
      res.edge_value = val[PIX_W-1:0];
      res.frame_last = last;
      pending_edges.push_back(res);
    end

    pc++;
    if (pc >= w) begin
      pc = 0;
      pr++;
    end
    col_pos = pc;
    row_pos = pr;
    if (last) restart_frame();
  endfunction

  function automatic pix_item_t pixel(input logic [PIX_W-1:0] r, g, b);
    pixel = '{req_type: REQ_PIXEL, red: r, green: g, blue: b};
  endfunction

  // Flush items carry junk colour, which the block must ignore
  function automatic pix_item_t flush_item();
    flush_item = '{req_type: REQ_FLUSH, red: PIX_W'($urandom_range(255)),
                   green: PIX_W'($urandom_range(255)), blue: PIX_W'($urandom_range(255))};
  endfunction

  // Queue one frame plus its trailing flushes; noise swaps item kinds, cut truncates
  function automatic int queue_frame(input int noise_pct, input bit extremes, input int cut);
    int        w, h, n;
    pix_item_t it;
    w = eff_w();
    h = eff_h();
    n = 0;
    for (int i = 0; i < w * h + w + 1; i++) begin
      if (cut > 0 && n == cut) break;
      if (extremes) begin
        it.red   = $urandom_range(1) ? EDGE_MAX : '0;
        it.green = $urandom_range(1) ? EDGE_MAX : '0;
        it.blue  = $urandom_range(1) ? EDGE_MAX : '0;
      end else begin
        it.red   = PIX_W'($urandom_range(255));
        it.green = PIX_W'($urandom_range(255));
        it.blue  = PIX_W'($urandom_range(255));
      end
      it.req_type = (i < w * h) ? REQ_PIXEL : REQ_FLUSH;
      if ($urandom_range(99) < noise_pct) it.req_type = ~it.req_type;
      pixel_backlog.push_back(it);
      n++;
    end
    return n;
  endfunction

  function automatic logic [CFG_W-1:0] pick_width();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 85) return CFG_W'($urandom_range(1, 12));
    return CFG_W'($urandom_range(13, 64));
  endfunction

  function automatic logic [CFG_W-1:0] pick_height();
    return ($urandom_range(99) < 5) ? '0 : CFG_W'($urandom_range(1, 6));
  endfunction

  function automatic void set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 50; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 50; end
      default:       begin send_idle_pct = 6;  recv_stall_pct = 6;  end
    endcase
  endfunction

  // Hold until every item is in and every result is out, then let the pipe settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_backlog.size() != 0 || pix_ch.valid || pending_edges.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    apply_config(idx, val);
    reg_writes++;
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive every input to a known value, clear the model, release reset
  initial begin
    rst_n           = 1'b0;
    pix_ch.valid    = 1'b0;
    pix_ch.req_type = REQ_PIXEL;
    pix_ch.red      = '0;
    pix_ch.green    = '0;
    pix_ch.blue     = '0;
    res_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_IMAGE_WIDTH;
    cfg_ch.data     = '0;
    for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
      upper_lum[i]  = '0;
      middle_lum[i] = '0;
    end
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++)
        win_lum[k][j] = '0;
    width_reg  = IMAGE_WIDTH_RST;
    height_reg = IMAGE_HEIGHT_RST;
    restart_frame();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: present backlog items, model each transfer as it happens
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        advance_sobel(driven_item);
        items_sent++;
      end
      if (!pix_ch.valid || pix_ch.ready) begin
        if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          driven_item = pixel_backlog.pop_front();
          pix_ch.valid    <= 1'b1;
          pix_ch.req_type <= driven_item.req_type;
          pix_ch.red      <= driven_item.red;
          pix_ch.green    <= driven_item.green;
          pix_ch.blue     <= driven_item.blue;
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expected edge value
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_edges.size() == 0) begin
          $error("unexpected result: edge_value %0d frame_last %0d",
                 res_ch.edge_value, res_ch.frame_last);
          fail_count++;
        end else begin
          want_edge = pending_edges.pop_front();
          if (res_ch.edge_value !== want_edge.edge_value) begin
            $error("edge_value: expected %0d, got %0d", want_edge.edge_value,
                   res_ch.edge_value);
            fail_count++;
          end
          if (res_ch.frame_last !== want_edge.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want_edge.frame_last,
                   res_ch.frame_last);
            fail_count++;
          end
          results_checked++;
          if (want_edge.frame_last) frames_seen++;
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : stimulus
    int rand_items;
    int seg;
    int nfr;
    int cut;
    bit broken;
    rand_items = 0;
    seg        = 0;
    broken     = 1'b1;
    wait (rst_n === 1'b1);
    @(negedge clk);
    set_idling(IDLE_NONE);

    // 3x3: white row over single-channel row, flush inside the image, pixel in the tail
    write_reg(REG_IMAGE_WIDTH, 11'd3);
    write_reg(REG_IMAGE_HEIGHT, 11'd3);
    repeat (3) pixel_backlog.push_back(pixel(8'hFF, 8'hFF, 8'hFF));
    pixel_backlog.push_back(pixel(8'hFF, 8'h00, 8'h00));
    pixel_backlog.push_back(pixel(8'h00, 8'hFF, 8'h00));
    pixel_backlog.push_back(pixel(8'h00, 8'h00, 8'hFF));
    pixel_backlog.push_back(flush_item());
    pixel_backlog.push_back(pixel(8'h00, 8'h00, 8'h00));
    pixel_backlog.push_back(pixel(8'h80, 8'h40, 8'h20));
    pixel_backlog.push_back(flush_item());
    pixel_backlog.push_back(pixel(8'hFF, 8'hFF, 8'hFF));
    pixel_backlog.push_back(flush_item());
    pixel_backlog.push_back(flush_item());
    wait_drained();

    // zero geometry behaves as 1x1
    write_reg(REG_IMAGE_WIDTH, 11'd0);
    write_reg(REG_IMAGE_HEIGHT, 11'd0);
    pixel_backlog.push_back(pixel(8'hFF, 8'hFF, 8'hFF));
    repeat (2) pixel_backlog.push_back(flush_item());
    wait_drained();

    // 2x2 black over white: negative gradient clamps to zero
    write_reg(REG_IMAGE_WIDTH, 11'd2);
    write_reg(REG_IMAGE_HEIGHT, 11'd2);
    repeat (2) pixel_backlog.push_back(pixel(8'h00, 8'h00, 8'h00));
    repeat (2) pixel_backlog.push_back(pixel(8'hFF, 8'hFF, 8'hFF));
    repeat (3) pixel_backlog.push_back(flush_item());
    wait_drained();

    // top of the tallest column; spare indexes must not disturb it
    write_reg(REG_IMAGE_WIDTH, 11'd1);
    write_reg(REG_IMAGE_HEIGHT, '1);
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, 11'd5);
    set_idling(IDLE_RECEIVER);
    void'(queue_frame(0, 1'b0, TALL_CUT));

    // random frames, mostly well formed, some noisy or truncated
    while (rand_items < RANDOM_ITEMS) begin
      wait_drained();
      set_idling(idle_mode_t'(seg % 4));
      if (broken || $urandom_range(3) != 0) begin
        case (seg == 0 ? 0 : $urandom_range(2))
          0: begin
            write_reg(REG_IMAGE_WIDTH, pick_width());
            write_reg(REG_IMAGE_HEIGHT, pick_height());
          end
          1:       write_reg(REG_IMAGE_WIDTH, pick_width());
          default: write_reg(REG_IMAGE_HEIGHT, pick_height());
        endcase
      end
      broken = ($urandom_range(9) == 0);
      nfr    = $urandom_range(1, 3);
      cut    = broken ? $urandom_range(1, eff_w() * eff_h() + eff_w()) : 0;
      for (int f = 0; f < nfr; f++)
        rand_items += queue_frame(($urandom_range(3) == 0) ? 5 : 0,
                                  $urandom_range(4) == 0, (f == nfr - 1) ? cut : 0);
      seg++;
    end
    wait_drained();

    $display("Ran %0d items (%0d random over %0d segments), checked %0d edge values,",
             items_sent, rand_items, seg, results_checked);
    $display("%0d complete frames, %0d register writes, four flow-control patterns.",
             frames_seen, reg_writes);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timed out with %0d results outstanding", pending_edges.size());
    $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
design/gvs_pkg.sv
design/gvs_if.sv
design/gvs_ram.sv
design/gvs_seq.sv
design/gvs_window.sv
design/gray_vertical_sobel_filter_unit.sv
tb/sv/testbench.sv
